// ===== sv/gcs_pkg.sv =====
package gcs_pkg;

	localparam int STENCIL_WIDTH = 3;
	localparam int CELL_COUNT    = STENCIL_WIDTH * STENCIL_WIDTH * STENCIL_WIDTH;
	localparam int ADDR_W        = $clog2(CELL_COUNT);
	localparam int COEF_W        = 32;
	localparam int RES_W         = 44;

	typedef logic [1:0]               idx_t;
	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [RES_W-1:0]  acc_t;

	localparam idx_t IDX_LAST = idx_t'(STENCIL_WIDTH - 1);

	// Offset code with no stencil position
	localparam logic [1:0] OFS_NONE  = 2'b10;
	localparam logic [1:0] OFS_MINUS = 2'b11;
	localparam logic [1:0] OFS_ZERO  = 2'b00;

	// Restriction pass: which axis of the stored array is contracted
	typedef enum logic [1:0] {
		PASS_A = 2'd0,
		PASS_B = 2'd1,
		PASS_C = 2'd2
	} pass_t;

	// Read issued by the sequencer, seen in the next cycle with the RAM data
	typedef struct packed {
		logic  vld;
		pass_t pass;
		idx_t  u;
		idx_t  v;
		idx_t  k;
		logic  keep;
	} issue_t;

	function automatic idx_t offset_index(logic [1:0] raw);
		idx_t r;
		unique case (raw)
			OFS_MINUS: r = 2'd0;
			OFS_ZERO:  r = 2'd1;
			default:   r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic addr_t cell_addr(idx_t i, idx_t j, idx_t k);
		addr_t ai;
		addr_t aj;
		addr_t ak;
		ai = addr_t'(i);
		aj = addr_t'(j);
		ak = addr_t'(k);
		return (ai << 3) + ai + (aj << 1) + aj + ak;
	endfunction

	// Address of element k of row (u,v) for a pass
	function automatic addr_t row_addr(pass_t pass, idx_t u, idx_t v, idx_t k);
		addr_t r;
		unique case (pass)
			PASS_A:  r = cell_addr(k, u, v);
			PASS_B:  r = cell_addr(u, k, v);
			default: r = cell_addr(v, u, k);
		endcase
		return r;
	endfunction

	// Output j of a row: sum over k of R[k][j] * e_k, R in sixteenths
	function automatic acc_t mix(acc_t e0, acc_t e1, acc_t e2, idx_t j);
		acc_t r;
		case (j)
			2'd0:    r = (e0 <<< 2) + e1;
			2'd1:    r = (e0 <<< 2) + (e1 <<< 2) + (e1 <<< 1) + (e2 <<< 2);
			default: r = e1 + (e2 <<< 2);
		endcase
		return r;
	endfunction

endpackage

// ===== sv/gcs_ram.sv =====
module gcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 27
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/gcs_ctrl.sv =====
module gcs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [1:0]    x_offset,
	input  logic signed [1:0]    y_offset,
	input  logic signed [1:0]    z_offset,
	input  gcs_pkg::coef_t       coefficient,
	input  logic                 last_entry,
	input  logic                 wr_pending,
	output logic                 busy,
	output logic                 st_we,
	output gcs_pkg::addr_t       st_waddr,
	output gcs_pkg::coef_t       st_wdata,
	output gcs_pkg::addr_t       rd_addr,
	output gcs_pkg::issue_t      issue_s1
);

	import gcs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	state_t                  state_q;
	pass_t                   pass_q;
	idx_t                    u_q;
	idx_t                    v_q;
	idx_t                    k_q;
	logic [CELL_COUNT-1:0]   valid_q;
	logic                    accept;
	logic                    ofs_ok;
	logic                    issuing;
	logic                    drained;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign ofs_ok  = (x_offset != OFS_NONE) && (y_offset != OFS_NONE) &&
		(z_offset != OFS_NONE);
	assign issuing = (state_q == ST_ISSUE);
	assign drained = !issue_s1.vld && !wr_pending;

	// Store the entry on transfer when all three offsets name a position
	assign st_we    = accept && ofs_ok;
	assign st_waddr = cell_addr(offset_index(x_offset), offset_index(y_offset),
		offset_index(z_offset));
	assign st_wdata = coefficient;

	assign rd_addr = row_addr(pass_q, u_q, v_q, k_q);

	// Sequence three restriction passes, one RAM read per cycle while issuing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pass_q   <= PASS_A;
			u_q      <= '0;
			v_q      <= '0;
			k_q      <= '0;
			valid_q  <= '0;
			issue_s1 <= '0;
		end else begin
			if (st_we) begin
				valid_q[st_waddr] <= 1'b1;
			end

			issue_s1.vld  <= issuing;
			issue_s1.pass <= pass_q;
			issue_s1.u    <= u_q;
			issue_s1.v    <= v_q;
			issue_s1.k    <= k_q;
			issue_s1.keep <= valid_q[rd_addr];

			unique case (state_q)
				ST_IDLE: begin
					if (accept && last_entry) begin
						state_q <= ST_ISSUE;
						pass_q  <= PASS_A;
						u_q     <= '0;
						v_q     <= '0;
						k_q     <= '0;
					end
				end
				ST_ISSUE: begin
					if (k_q == IDX_LAST) begin
						k_q <= '0;
						if (v_q == IDX_LAST) begin
							v_q <= '0;
							u_q <= (u_q == IDX_LAST) ? '0 : u_q + 2'd1;
							if (u_q == IDX_LAST) begin
								state_q <= ST_DRAIN;
							end
						end else begin
							v_q <= v_q + 2'd1;
						end
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_DRAIN: begin
					// Wait for the last write-back before the next pass reads
					if (drained) begin
						if (pass_q == PASS_C) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_ISSUE;
							pass_q  <= (pass_q == PASS_A) ? PASS_B : PASS_C;
							if (pass_q == PASS_A) begin
								valid_q <= '0;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/gcs_dp.sv =====
module gcs_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  gcs_pkg::issue_t  issue_s1,
	input  gcs_pkg::coef_t   st_rdata,
	input  gcs_pkg::acc_t    wk_rdata,
	output logic             wk_we,
	output gcs_pkg::addr_t   wk_waddr,
	output gcs_pkg::acc_t    wk_wdata,
	output logic             wr_pending,
	output logic             strobe,
	output logic [1:0]       first_index,
	output logic [1:0]       second_index,
	output logic [1:0]       third_index,
	output gcs_pkg::acc_t    coarse_coefficient,
	output logic             last_result
);

	import gcs_pkg::*;

	acc_t  elem;
	acc_t  e0_q;
	acc_t  e1_q;
	acc_t  h0_s2;
	acc_t  h1_s2;
	acc_t  h2_s2;
	pass_t pass_s2;
	idx_t  u_s2;
	idx_t  v_s2;
	idx_t  j_q;
	logic  wr_act_q;
	logic  row_done;
	logic  emit;
	acc_t  mix_out;

	// Select the element: unwritten stencil positions read as zero
	always_comb begin
		if (issue_s1.pass == PASS_A) begin
			elem = issue_s1.keep ? acc_t'(st_rdata) : '0;
		end else begin
			elem = wk_rdata;
		end
	end

	assign row_done = issue_s1.vld && (issue_s1.k == IDX_LAST);
	assign mix_out  = mix(h0_s2, h1_s2, h2_s2, j_q);
	assign emit     = wr_act_q && (pass_s2 == PASS_C);

	// Write back the row in place, or emit it on the last pass
	assign wk_we      = wr_act_q && (pass_s2 != PASS_C);
	assign wk_waddr   = row_addr(pass_s2, u_s2, v_s2, j_q);
	assign wk_wdata   = mix_out;
	assign wr_pending = wr_act_q;

	// Capture the row, then hold it while its three outputs are written
	always_ff @(posedge clk) begin
		if (issue_s1.vld && issue_s1.k == 2'd0) begin
			e0_q <= elem;
		end
		if (issue_s1.vld && issue_s1.k == 2'd1) begin
			e1_q <= elem;
		end
		if (row_done) begin
			h0_s2   <= e0_q;
			h1_s2   <= e1_q;
			h2_s2   <= elem;
			pass_s2 <= issue_s1.pass;
			u_s2    <= issue_s1.u;
			v_s2    <= issue_s1.v;
		end
		if (emit) begin
			first_index        <= u_s2;
			second_index       <= v_s2;
			third_index        <= j_q;
			coarse_coefficient <= mix_out;
			last_result        <= (u_s2 == IDX_LAST) && (v_s2 == IDX_LAST) &&
				(j_q == IDX_LAST);
		end
	end

	// Count write slots and drive the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_act_q <= 1'b0;
			j_q      <= '0;
			strobe   <= 1'b0;
		end else begin
			strobe <= emit;
			if (row_done) begin
				wr_act_q <= 1'b1;
				j_q      <= '0;
			end else if (wr_act_q) begin
				if (j_q == IDX_LAST) begin
					wr_act_q <= 1'b0;
					j_q      <= '0;
				end else begin
					j_q <= j_q + 2'd1;
				end
			end
		end
	end

endmodule

// ===== sv/galerkin_coarse_stencil_3d_core.sv =====
// Channel   Transfer when           Fields
// input     start && !busy          x_offset, y_offset, z_offset, coefficient, last_entry
// result    strobe (one cycle)      first_index, second_index, third_index,
//                                   coarse_coefficient, last_result
//
// An entry without last_entry leaves busy low.
// On the entry with last_entry, busy is high for three restriction passes:
// the first over the stencil RAM, the others over the 27-entry work RAM, each
// reading every row and then draining the write-back. The 27 results come on
// the third pass, back to back in rows of three. Reset and each burst clear
// the stencil store. The receiver cannot stall; results are never held.
module galerkin_coarse_stencil_3d_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [1:0]    x_offset,
	input  logic signed [1:0]    y_offset,
	input  logic signed [1:0]    z_offset,
	input  gcs_pkg::coef_t       coefficient,
	input  logic                 last_entry,
	output logic                 strobe,
	output logic [1:0]           first_index,
	output logic [1:0]           second_index,
	output logic [1:0]           third_index,
	output gcs_pkg::acc_t        coarse_coefficient,
	output logic                 last_result
);

	import gcs_pkg::*;

	logic    st_we;
	addr_t   st_waddr;
	coef_t   st_wdata;
	coef_t   st_rdata;
	addr_t   rd_addr;
	issue_t  issue_s1;
	logic    wk_we;
	addr_t   wk_waddr;
	acc_t    wk_wdata;
	acc_t    wk_rdata;
	logic    wr_pending;

	gcs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.x_offset    (x_offset),
		.y_offset    (y_offset),
		.z_offset    (z_offset),
		.coefficient (coefficient),
		.last_entry  (last_entry),
		.wr_pending  (wr_pending),
		.busy        (busy),
		.st_we       (st_we),
		.st_waddr    (st_waddr),
		.st_wdata    (st_wdata),
		.rd_addr     (rd_addr),
		.issue_s1    (issue_s1)
	);

	gcs_ram #(
		.WIDTH (COEF_W),
		.DEPTH (CELL_COUNT)
	) u_stencil_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (rd_addr),
		.rdata (st_rdata)
	);

	gcs_ram #(
		.WIDTH (RES_W),
		.DEPTH (CELL_COUNT)
	) u_work_ram (
		.clk   (clk),
		.we    (wk_we),
		.waddr (wk_waddr),
		.wdata (wk_wdata),
		.raddr (rd_addr),
		.rdata (wk_rdata)
	);

	gcs_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.issue_s1           (issue_s1),
		.st_rdata           (st_rdata),
		.wk_rdata           (wk_rdata),
		.wk_we              (wk_we),
		.wk_waddr           (wk_waddr),
		.wk_wdata           (wk_wdata),
		.wr_pending         (wr_pending),
		.strobe             (strobe),
		.first_index        (first_index),
		.second_index       (second_index),
		.third_index        (third_index),
		.coarse_coefficient (coarse_coefficient),
		.last_result        (last_result)
	);

endmodule

// ===== sv/gcs_check.sv =====
module gcs_check (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       last_entry,
	input logic       strobe,
	input logic [1:0] first_index,
	input logic [1:0] second_index,
	input logic [1:0] third_index,
	input logic       last_result
);

	// An entry transfer starts a burst exactly when it is marked last
	a_burst_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy == $past(last_entry))
		else $error("busy does not follow the last entry");

	// Results only appear inside a burst
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy)
		else $error("result transfer while idle");

	// The three results of a row come back to back
	a_row_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && third_index != 2'd2 |=> strobe &&
		third_index == $past(third_index) + 2'd1 &&
		first_index == $past(first_index) && second_index == $past(second_index))
		else $error("row of results broken");

	// The final result is the corner element
	a_last_corner: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_result |-> first_index == 2'd2 && second_index == 2'd2 &&
		third_index == 2'd2)
		else $error("last result on wrong element");

endmodule

bind galerkin_coarse_stencil_3d_core gcs_check u_gcs_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last_entry   (last_entry),
	.strobe       (strobe),
	.first_index  (first_index),
	.second_index (second_index),
	.third_index  (third_index),
	.last_result  (last_result)
);

// ===== bench/coarse_stencil_checker.sv =====
`timescale 1ns / 1ps

// Watch the entry and result channels of the coarse stencil core. Predict
// the 27 coarse coefficients from the collected fine stencil and compare
// each result in order.
module coarse_stencil_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [1:0]           x_offset,
	input  logic [1:0]           y_offset,
	input  logic [1:0]           z_offset,
	input  gcs_pkg::coef_t       coefficient,
	input  logic                 last_entry,
	input  logic                 strobe,
	input  logic [1:0]           first_index,
	input  logic [1:0]           second_index,
	input  logic [1:0]           third_index,
	input  gcs_pkg::acc_t        coarse_coefficient,
	input  logic                 last_result,
	output int                   mismatches,
	output int                   outstanding
);

	import gcs_pkg::*;

	// 1-D restriction weights in sixteenths, indexed [fine][coarse]
	localparam int RESTRICT16 [STENCIL_WIDTH][STENCIL_WIDTH] =
		'{'{4, 4, 0}, '{1, 6, 1}, '{0, 4, 4}};

	typedef struct {
		idx_t p;
		idx_t q;
		idx_t s;
		acc_t value;
		logic last;
	} coarse_t;

	coarse_t coarse_q[$];
	coef_t   fine_coef [CELL_COUNT];
	int      results_seen;

	initial begin
		mismatches   = 0;
		outstanding  = 0;
		results_seen = 0;
	end

	task automatic report_mismatch(string what, logic signed [63:0] got,
		logic signed [63:0] want);
		$display("mismatch at result %0d, %s: got %0d, expected %0d",
			results_seen, what, got, want);
		mismatches++;
	endtask

	// Map an offset to a stencil index; the unused pattern has no position
	function automatic int axis_index(logic [1:0] raw);
		int r;
		case (raw)
			OFS_MINUS: r = 0;
			OFS_ZERO:  r = 1;
			OFS_NONE:  r = -1;
			default:   r = 2;
		endcase
		return r;
	endfunction

	// Form R^T A R with the first two coarse axes swapped, then clear the stencil
	task automatic restrict_stencil();
		int      p, q, s, a, b, c;
		longint  acc;
		coarse_t item;
		for (p = 0; p < STENCIL_WIDTH; p++)
			for (q = 0; q < STENCIL_WIDTH; q++)
				for (s = 0; s < STENCIL_WIDTH; s++) begin
					acc = 0;
					for (a = 0; a < STENCIL_WIDTH; a++)
						for (b = 0; b < STENCIL_WIDTH; b++)
							for (c = 0; c < STENCIL_WIDTH; c++)
								acc += longint'(fine_coef[(a * 3 + b) * 3 + c]) *
									RESTRICT16[a][q] * RESTRICT16[b][p] * RESTRICT16[c][s];
					item.p     = idx_t'(p);
					item.q     = idx_t'(q);
					item.s     = idx_t'(s);
					item.value = acc_t'(acc);
					item.last  = (p == 2 && q == 2 && s == 2);
					coarse_q.push_back(item);
				end
		foreach (fine_coef[i])
			fine_coef[i] = '0;
	endtask

	task automatic absorb_entry();
		int a, b, c;
		a = axis_index(x_offset);
		b = axis_index(y_offset);
		c = axis_index(z_offset);
		if (a >= 0 && b >= 0 && c >= 0)
			fine_coef[(a * 3 + b) * 3 + c] = coefficient;
		if (last_entry)
			restrict_stencil();
	endtask

	task automatic check_result();
		coarse_t want;
		if (coarse_q.size() == 0) begin
			report_mismatch("result with none expected, strobe", 1, 0);
			return;
		end
		want = coarse_q.pop_front();
		if (first_index !== want.p)
			report_mismatch("first_index", first_index, want.p);
		if (second_index !== want.q)
			report_mismatch("second_index", second_index, want.q);
		if (third_index !== want.s)
			report_mismatch("third_index", third_index, want.s);
		if (coarse_coefficient !== want.value)
			report_mismatch("coarse_coefficient", coarse_coefficient, want.value);
		if (last_result !== want.last)
			report_mismatch("last_result", last_result, want.last);
	endtask

	// Check results first, then take in the transfer on the entry channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (fine_coef[i])
				fine_coef[i] = '0;
			coarse_q.delete();
			outstanding <= 0;
		end else begin
			if (strobe) begin
				check_result();
				results_seen++;
			end
			if (start && !busy)
				absorb_entry();
			outstanding <= coarse_q.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import gcs_pkg::*;

	localparam int ENTRY_COUNT = 310;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  x_offset;
	logic [1:0]  y_offset;
	logic [1:0]  z_offset;
	coef_t       coefficient;
	logic        last_entry;
	logic        strobe;
	logic [1:0]  first_index;
	logic [1:0]  second_index;
	logic [1:0]  third_index;
	acc_t        coarse_coefficient;
	logic        last_result;
	int          mismatches;
	int          outstanding;

	int          entries_sent;
	int          burst_left;
	bit          calm;
	int unsigned cycle_count;

	galerkin_coarse_stencil_3d_core u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.x_offset           (x_offset),
		.y_offset           (y_offset),
		.z_offset           (z_offset),
		.coefficient        (coefficient),
		.last_entry         (last_entry),
		.strobe             (strobe),
		.first_index        (first_index),
		.second_index       (second_index),
		.third_index        (third_index),
		.coarse_coefficient (coarse_coefficient),
		.last_result        (last_result)
	);

	coarse_stencil_checker u_check (
		.clk                (clk),
		.arst_n             (arst_n),
		.start              (start),
		.busy               (busy),
		.x_offset           (x_offset),
		.y_offset           (y_offset),
		.z_offset           (z_offset),
		.coefficient        (coefficient),
		.last_entry         (last_entry),
		.strobe             (strobe),
		.first_index        (first_index),
		.second_index       (second_index),
		.third_index        (third_index),
		.coarse_coefficient (coarse_coefficient),
		.last_result        (last_result),
		.mismatches         (mismatches),
		.outstanding        (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// End a hung run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** galerkin_coarse_stencil_3d_core: FAILED **");
		$finish;
	end

	// Stencil index 0..2 to its offset -1..1
	function automatic logic [1:0] axis_code(int i);
		return 2'(i) - 2'd1;
	endfunction

	function automatic coef_t pick_coef();
		coef_t c;
		case ($urandom_range(0, 5))
			0:       c = 32'sh7FFF_FFFF;
			1:       c = 32'sh8000_0000;
			2:       c = coef_t'($urandom_range(0, 2)) - 32'sd1;
			3:       c = coef_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
			default: c = coef_t'($urandom);
		endcase
		return c;
	endfunction

	// Hold start through a burst; drop it for a random gap between bursts
	task automatic send_entry(input logic [1:0] xo, input logic [1:0] yo,
		input logic [1:0] zo, input coef_t c, input logic le);
		int gap;
		if (burst_left == 0) begin
			gap = 0;
			if (!calm)
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 110)
					: $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end else begin
			burst_left--;
		end
		x_offset    <= xo;
		y_offset    <= yo;
		z_offset    <= zo;
		coefficient <= c;
		last_entry  <= le;
		start       <= 1'b1;
		do @(posedge clk); while (busy);
		entries_sent++;
	endtask

	task automatic send_cell(input int pos, input coef_t c, input logic le);
		send_entry(axis_code(pos / 9), axis_code((pos / 3) % 3), axis_code(pos % 3), c, le);
	endtask

	// Entry with at least one offset on the unused pattern
	task automatic send_noise(input logic le);
		logic [1:0] ofs [3];
		foreach (ofs[i])
			ofs[i] = 2'($urandom);
		ofs[$urandom_range(0, 2)] = OFS_NONE;
		send_entry(ofs[0], ofs[1], ofs[2], pick_coef(), le);
	endtask

	// Hold off the sender until every expected result has come
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// One stencil: either all 27 positions shuffled or a few random ones,
	// closed by the last entry, with some stray entries mixed in
	task automatic send_stencil_set();
		int  order [CELL_COUNT];
		int  n, j, t;
		bit  full;
		full = ($urandom_range(0, 3) == 0);
		foreach (order[i])
			order[i] = i;
		if (full) begin
			for (int i = CELL_COUNT - 1; i > 0; i--) begin
				j        = $urandom_range(0, i);
				t        = order[i];
				order[i] = order[j];
				order[j] = t;
			end
			n = CELL_COUNT;
		end else begin
			n = $urandom_range(1, 12);
			for (int i = 0; i < n; i++)
				order[i] = $urandom_range(0, CELL_COUNT - 1);
		end
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_noise(1'b0);
			if (i == n - 1 && $urandom_range(0, 11) == 0)
				send_noise(1'b1);
			else
				send_cell(order[i], pick_coef(), i == n - 1);
		end
	endtask

	initial begin
		arst_n      <= 1'b0;
		start       <= 1'b0;
		x_offset    <= '0;
		y_offset    <= '0;
		z_offset    <= '0;
		coefficient <= '0;
		last_entry  <= 1'b0;
		entries_sent = 0;
		burst_left   = 0;
		calm         = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lone center entry on an empty store
		send_cell(13, 32'sh0001_0000, 1'b1);
		// Corner extremes, a repeated position, close on an unused offset
		send_cell(0, 32'sh7FFF_FFFF, 1'b0);
		send_cell(26, 32'sh8000_0000, 1'b0);
		send_cell(2, -32'sd1, 1'b0);
		send_cell(24, 32'sd0, 1'b0);
		send_cell(13, 32'sh1234_5678, 1'b0);
		send_cell(13, 32'shFFFE_8000, 1'b0);
		send_entry(OFS_NONE, OFS_ZERO, OFS_ZERO, 32'sh7FFF_0000, 1'b1);
		wait_drained();
		// Ignored entries, then a fresh stencil after the clear
		send_entry(OFS_ZERO, OFS_NONE, OFS_MINUS, 32'sh5555_5555, 1'b0);
		send_entry(OFS_MINUS, OFS_MINUS, OFS_NONE, 32'shAAAA_AAAA, 1'b0);
		send_cell(26, 32'sh8000_0000, 1'b0);
		send_cell(20, 32'sh7FFF_FFFF, 1'b0);
		send_cell(6, 32'sh0000_8000, 1'b1);
		// Zero entry: everything must come out zero after the clear
		calm = 1'b1;
		send_cell(4, 32'sd0, 1'b1);
		wait_drained();

		// Random stencils up to the entry budget
		while (entries_sent < ENTRY_COUNT) begin
			calm = ($urandom_range(0, 3) == 0);
			send_stencil_set();
			if ($urandom_range(0, 5) == 0)
				wait_drained();
		end

		// Drain and let the core settle
		wait_drained();
		repeat (150) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("** galerkin_coarse_stencil_3d_core: PASSED **");
		else
			$display("** galerkin_coarse_stencil_3d_core: FAILED **");
		$finish;
	end

endmodule
